// ===== design/mscv_pkg.sv =====
// Shared constants for the sliding-window loudness spread suppressor.
package mscv_pkg;

  localparam int HALF_WINDOW_DEFAULT = 50;
  localparam int MAX_FRAMES_DEFAULT  = 65536;

  localparam int LOUD_W = 16;
  localparam int PROB_W = 17;
  localparam int REG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_FRAME_COUNT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPREAD_LIMIT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_FRAMES   = 2'd2;

  localparam logic [REG_W-1:0] FRAME_COUNT_RESET  = 16'd0;
  localparam logic [REG_W-1:0] SPREAD_LIMIT_RESET = 16'd22938;
  localparam logic [REG_W-1:0] MIN_FRAMES_RESET   = 16'd200;

endpackage

// ===== design/music_suppress_window_cv_unit.sv =====
// Loudness spread suppressor: windowed coefficient of variation scales speech probability.
//
// Each frame brings a loudness and a speech probability. For each frame the block forms
// the spread (standard deviation over mean) of loudness over a window of HALF_WINDOW
// frames on each side, clipped at the sequence ends, and, when frame_count reaches
// min_frames and the spread is below spread_limit, scales the probability by spread /
// spread_limit. Results lag the input by HALF_WINDOW frames, and the final frame of a
// sequence (set by frame_count) flushes every pending result. One shared multiplier, a
// one-bit-per-cycle square root and a one-bit-per-cycle divider do the work under a
// sequencer, so the block takes one request at a time. Taking in a frame takes longer
// once the oldest frame has to leave the window, since it is first taken out of the
// sums. Each result's time is set by the square root and the two divisions; a silent
// window, a saturated spread or a result that needs no scaling is faster. The final
// frame also runs its flush, up to HALF_WINDOW more results, retiring each frame that
// leaves the window on the way. A result that waits at the output holds the sequencer
// until it is taken.
module music_suppress_window_cv_unit #(
  parameter int HALF_WINDOW = mscv_pkg::HALF_WINDOW_DEFAULT,
  parameter int MAX_FRAMES  = mscv_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [39:0]               s_tdata,   // loudness[15:0], probability_in[32:16], zeros
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,   // probability_out[16:0], frame_index[32:17], zeros
  output logic                      m_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mscv_pkg::IDX_W-1:0] cfg_index,
  input  logic [mscv_pkg::REG_W-1:0] cfg_data
);
  import mscv_pkg::*;

  localparam int LDEPTH = 2 * HALF_WINDOW + 1;
  localparam int PDEPTH = HALF_WINDOW + 1;
  localparam int LA     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int PA     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int CNT_W  = $clog2(2 * HALF_WINDOW + 2);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int SQ_W   = 32 + CNT_W;
  localparam int DW     = 2 * SUM_W;
  localparam int SC_W   = $clog2(SUM_W + 1);

  localparam logic [LA-1:0]    L_LAST = LA'(LDEPTH - 1);
  localparam logic [PA-1:0]    P_LAST = PA'(PDEPTH - 1);
  localparam logic [16:0]      H17    = 17'(HALF_WINDOW);
  localparam logic [16:0]      H2_17  = 17'(2 * HALF_WINDOW);
  localparam logic [16:0]      L17    = 17'(LDEPTH);
  localparam logic [16:0]      MAXF   = 17'(MAX_FRAMES);
  localparam logic [SC_W-1:0]  SQ_STEPS = SC_W'(SUM_W);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RD    = 5'd1;
  localparam logic [4:0] ST_DSQ   = 5'd2;
  localparam logic [4:0] ST_DSUB  = 5'd3;
  localparam logic [4:0] ST_ADD   = 5'd4;
  localparam logic [4:0] ST_ADDQ  = 5'd5;
  localparam logic [4:0] ST_FCHK  = 5'd6;
  localparam logic [4:0] ST_EA    = 5'd7;
  localparam logic [4:0] ST_EB    = 5'd8;
  localparam logic [4:0] ST_EC    = 5'd9;
  localparam logic [4:0] ST_ED    = 5'd10;
  localparam logic [4:0] ST_SQRT  = 5'd11;
  localparam logic [4:0] ST_DIV1I = 5'd12;
  localparam logic [4:0] ST_DIV1  = 5'd13;
  localparam logic [4:0] ST_MUL2  = 5'd14;
  localparam logic [4:0] ST_DIV2I = 5'd15;
  localparam logic [4:0] ST_DIV2  = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [REG_W-1:0] frame_count, spread_limit, min_frames;

  logic [4:0]        state;
  logic [15:0]       frames_in, icur, cur_lo;
  logic              fin, flushing, apply, last_flag;
  logic [15:0]       lv;
  logic [16:0]       pin, prob, jcur;
  logic [SUM_W-1:0]  wsum;
  logic [SQ_W-1:0]   wsq;
  logic [CNT_W-1:0]  cw;
  logic [LA-1:0]     wp, dp;
  logic [PA-1:0]     pwp, ep;
  logic [DW-1:0]     acc, prod, sq_d;
  logic [SUM_W:0]    sq_rem;
  logic [SUM_W-1:0]  sq_root;
  logic [SC_W-1:0]   cnt;
  logic [SUM_W-1:0]  dv_rem, dv_div;
  logic [16:0]       dv_n, dv_q;
  logic [15:0]       sp;
  logic [15:0]       lrd;
  logic [16:0]       prd;

  logic [15:0] lring [LDEPTH];
  logic [16:0] pring [PDEPTH];

  logic [16:0]      eff, lo17, jcur_next;
  logic [SUM_W-1:0] mul_a, mul_b;
  logic [LA-1:0]    lr_addr;
  logic [SUM_W+2:0] sq_remx, sq_trial;
  logic             sq_ge;
  logic [SUM_W:0]   dv_remx;
  logic             dv_ge;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    eff = (frame_count == '0) ? 17'd1 : {1'b0, frame_count};
    if (eff > MAXF) begin
      eff = MAXF;
    end
    lo17      = (jcur >= H17) ? jcur - H17 : 17'd0;
    jcur_next = jcur + 17'd1;
    lr_addr   = flushing ? dp : wp;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_DSQ: begin
        mul_a = SUM_W'(lrd);
        mul_b = SUM_W'(lrd);
      end
      ST_ADD: begin
        mul_a = SUM_W'(lv);
        mul_b = SUM_W'(lv);
      end
      ST_EA: begin
        mul_a = SUM_W'(cw);
        mul_b = wsq[SUM_W-1:0];
      end
      ST_EB: begin
        mul_a = SUM_W'(cw);
        mul_b = SUM_W'(wsq[SQ_W-1:SUM_W]);
      end
      ST_EC: begin
        mul_a = wsum;
        mul_b = wsum;
      end
      ST_MUL2: begin
        mul_a = SUM_W'(prob);
        mul_b = SUM_W'(sp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sq_remx  = {sq_rem, sq_d[DW-1:DW-2]};
    sq_trial = {1'b0, sq_root, 2'b01};
    sq_ge    = (sq_remx >= sq_trial);
    dv_remx  = {dv_rem, dv_n[16]};
    dv_ge    = (dv_remx >= {1'b0, dv_div});
  end

  always_ff @(posedge clk) begin
    prod <= DW'(mul_a * mul_b);
    lrd  <= lring[lr_addr];
    prd  <= pring[ep];
    if (state == ST_ADD) begin
      lring[wp]  <= lv;
      pring[pwp] <= pin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= FRAME_COUNT_RESET;
      spread_limit <= SPREAD_LIMIT_RESET;
      min_frames   <= MIN_FRAMES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_COUNT:  frame_count  <= cfg_data;
        REG_SPREAD_LIMIT: spread_limit <= cfg_data;
        REG_MIN_FRAMES:   min_frames   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      frames_in <= '0;
      wsum      <= '0;
      wsq       <= '0;
      cw        <= '0;
      wp        <= '0;
      pwp       <= '0;
      flushing  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        ST_IDLE: begin
          if (s_tvalid) begin
            lv       <= s_tdata[15:0];
            pin      <= s_tdata[32:16];
            icur     <= frames_in;
            fin      <= ({1'b0, frames_in} + 17'd1 >= eff);
            flushing <= 1'b0;
            state    <= ({1'b0, frames_in} >= L17) ? ST_RD : ST_ADD;
          end
        end
        ST_RD: begin
          state <= ST_DSQ;
        end
        ST_DSQ: begin
          wsum  <= wsum - SUM_W'(lrd);
          cw    <= cw - CNT_W'(1);
          state <= ST_DSUB;
        end
        ST_DSUB: begin
          wsq <= wsq - SQ_W'(prod);
          if (flushing) begin
            cur_lo <= cur_lo + 16'd1;
            dp     <= (dp == L_LAST) ? '0 : dp + LA'(1);
            state  <= ST_FCHK;
          end else begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          wsum  <= wsum + SUM_W'(lv);
          cw    <= cw + CNT_W'(1);
          ep    <= ({1'b0, icur} >= H17) ? ((pwp == P_LAST) ? '0 : pwp + PA'(1)) : '0;
          state <= ST_ADDQ;
        end
        ST_ADDQ: begin
          wsq       <= wsq + SQ_W'(prod);
          wp        <= (wp == L_LAST) ? '0 : wp + LA'(1);
          pwp       <= (pwp == P_LAST) ? '0 : pwp + PA'(1);
          dp        <= ({1'b0, icur} >= H2_17) ? ((wp == L_LAST) ? '0 : wp + LA'(1)) : '0;
          cur_lo    <= ({1'b0, icur} >= H2_17) ? 16'(({1'b0, icur} - H2_17)) : 16'd0;
          jcur      <= ({1'b0, icur} >= H17) ? {1'b0, icur} - H17 : 17'd0;
          last_flag <= 1'b0;
          if ({1'b0, icur} >= H17) begin
            state <= ST_EA;
          end else if (fin) begin
            flushing <= 1'b1;
            state    <= ST_FCHK;
          end else begin
            frames_in <= icur + 16'd1;
            state     <= ST_IDLE;
          end
        end
        ST_FCHK: begin
          if (jcur > {1'b0, icur}) begin
            wsum      <= '0;
            wsq       <= '0;
            cw        <= '0;
            wp        <= '0;
            pwp       <= '0;
            frames_in <= '0;
            flushing  <= 1'b0;
            state     <= ST_IDLE;
          end else if ({1'b0, cur_lo} < lo17) begin
            state <= ST_RD;
          end else begin
            last_flag <= (jcur == {1'b0, icur});
            state     <= ST_EA;
          end
        end
        ST_EA: begin
          apply <= (eff >= {1'b0, min_frames}) && (wsum >= SUM_W'(cw));
          state <= ST_EB;
        end
        ST_EB: begin
          prob  <= prd;
          acc   <= prod;
          state <= ST_EC;
        end
        ST_EC: begin
          acc   <= acc + (prod << SUM_W);
          state <= ST_ED;
        end
        ST_ED: begin
          sq_d    <= (acc > prod) ? acc - prod : '0;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= SQ_STEPS;
          state   <= apply ? ST_SQRT : ST_OUT;
        end
        ST_SQRT: begin
          sq_d <= sq_d << 2;
          if (sq_ge) begin
            sq_rem  <= (SUM_W + 1)'(sq_remx - sq_trial);
            sq_root <= {sq_root[SUM_W-2:0], 1'b1};
          end else begin
            sq_rem  <= (SUM_W + 1)'(sq_remx);
            sq_root <= {sq_root[SUM_W-2:0], 1'b0};
          end
          cnt <= cnt - SC_W'(1);
          if (cnt == SC_W'(1)) begin
            state <= ST_DIV1I;
          end
        end
        ST_DIV1I: begin
          if (sq_root >= wsum) begin
            sp    <= 16'hFFFF;
            state <= ST_MUL2;
          end else begin
            dv_rem <= sq_root;
            dv_div <= wsum;
            dv_n   <= '0;
            dv_q   <= '0;
            cnt    <= SC_W'(16);
            state  <= ST_DIV1;
          end
        end
        ST_DIV2I: begin
          dv_rem <= SUM_W'(prod[32:17]);
          dv_div <= SUM_W'(spread_limit);
          dv_n   <= prod[16:0];
          dv_q   <= '0;
          cnt    <= SC_W'(17);
          state  <= ST_DIV2;
        end
        ST_DIV1, ST_DIV2: begin
          dv_rem <= dv_ge ? SUM_W'(dv_remx - {1'b0, dv_div}) : SUM_W'(dv_remx);
          dv_q   <= {dv_q[15:0], dv_ge};
          dv_n   <= dv_n << 1;
          cnt    <= cnt - SC_W'(1);
          if (cnt == SC_W'(1)) begin
            if (state == ST_DIV1) begin
              sp    <= {dv_q[14:0], dv_ge};
              state <= ST_MUL2;
            end else begin
              prob  <= {dv_q[15:0], dv_ge};
              state <= ST_OUT;
            end
          end
        end
        ST_MUL2: begin
          if (spread_limit == '0 || sp >= spread_limit) begin
            state <= ST_OUT;
          end else begin
            state <= ST_DIV2I;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, jcur[15:0], prob};
            m_tlast  <= last_flag;
            ep       <= (ep == P_LAST) ? '0 : ep + PA'(1);
            if (fin) begin
              flushing <= 1'b1;
              jcur     <= jcur_next;
              state    <= ST_FCHK;
            end else begin
              frames_in <= icur + 16'd1;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/mscv_checker.sv =====
// Checker for the loudness spread suppressor: predicts each result and compares it.
module mscv_checker #(
  parameter int HALF_WINDOW = mscv_pkg::HALF_WINDOW_DEFAULT,
  parameter int MAX_FRAMES  = mscv_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [39:0]                s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [39:0]                m_tdata,
  input  logic                       m_tlast,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [mscv_pkg::IDX_W-1:0] cfg_index,
  input  logic [mscv_pkg::REG_W-1:0] cfg_data,
  output int unsigned                fail_count,
  output int unsigned                outstanding
);
  import mscv_pkg::*;

  localparam int LRING = 2 * HALF_WINDOW + 1;
  localparam int PRING = HALF_WINDOW + 1;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [15:0]       frame;
    logic              last;
  } frame_result_t;

  frame_result_t     pending_results[$];
  logic [REG_W-1:0]  frame_count, spread_limit, min_frames;
  logic [LOUD_W-1:0] loud_hist[LRING];
  logic [PROB_W-1:0] prob_hist[PRING];
  longint unsigned   loud_sum, loud_sq_sum;
  int unsigned       next_in;

  assign outstanding = pending_results.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned live_count();
    longint unsigned n;
    n = (frame_count == 0) ? 1 : frame_count;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  task automatic retire_frame(int unsigned f);
    longint unsigned v;
    v = loud_hist[f % LRING];
    loud_sum -= v;
    loud_sq_sum -= v * v;
  endtask

  task automatic scale_frame(int unsigned j, longint unsigned cnt, bit is_last);
    longint unsigned p, a, b, d, sp;
    frame_result_t r;
    p = prob_hist[j % PRING];
    if (live_count() >= min_frames && cnt > 0 && loud_sum >= cnt) begin
      a = cnt * loud_sq_sum;
      b = loud_sum * loud_sum;
      d = (a > b) ? a - b : 0;
      sp = (int_sqrt(d) << 16) / loud_sum;
      if (sp > 65535) sp = 65535;
      if (spread_limit != 0 && sp < spread_limit) p = (p * sp) / spread_limit;
    end
    r.prob = p[PROB_W-1:0];
    r.frame = j[15:0];
    r.last = is_last;
    pending_results = {pending_results, r};
  endtask

  task automatic absorb_frame(logic [LOUD_W-1:0] lv, logic [PROB_W-1:0] pv);
    int unsigned i, lo, cur_lo, j;
    bit closing;
    i = next_in;
    closing = (i + 1 >= live_count());
    if (i >= LRING) retire_frame(i);
    loud_hist[i % LRING] = lv;
    loud_sum += lv;
    loud_sq_sum += longint'(lv) * lv;
    prob_hist[i % PRING] = pv;
    if (i >= HALF_WINDOW) begin
      lo = (i >= 2 * HALF_WINDOW) ? i - 2 * HALF_WINDOW : 0;
      scale_frame(i - HALF_WINDOW, i - lo + 1, 0);
    end
    if (closing) begin
      cur_lo = (i >= 2 * HALF_WINDOW) ? i - 2 * HALF_WINDOW : 0;
      j = (i >= HALF_WINDOW) ? i - HALF_WINDOW + 1 : 0;
      for (; j <= i; j++) begin
        lo = (j >= HALF_WINDOW) ? j - HALF_WINDOW : 0;
        while (cur_lo < lo) begin
          retire_frame(cur_lo);
          cur_lo++;
        end
        scale_frame(j, i - lo + 1, j == i);
      end
      loud_sum = 0;
      loud_sq_sum = 0;
      next_in = 0;
    end else begin
      next_in = (i + 1) & 16'hFFFF;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      spread_limit <= SPREAD_LIMIT_RESET;
      min_frames <= MIN_FRAMES_RESET;
      for (int k = 0; k < LRING; k++) loud_hist[k] = '0;
      for (int k = 0; k < PRING; k++) prob_hist[k] = '0;
      loud_sum = 0;
      loud_sq_sum = 0;
      next_in = 0;
      pending_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_COUNT: frame_count <= cfg_data;
          REG_SPREAD_LIMIT: spread_limit <= cfg_data;
          REG_MIN_FRAMES: min_frames <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) absorb_frame(s_tdata[15:0], s_tdata[32:16]);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: prob %0d frame %0d last %0b",
                     m_tdata[16:0], m_tdata[32:17], m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.prob !== m_tdata[16:0] || want.frame !== m_tdata[32:17] ||
              want.last !== m_tlast) begin
            if (fail_count < 10)
              $display("mismatch: expected prob %0d frame %0d last %0b, got %0d %0d %0b",
                       want.prob, want.frame, want.last,
                       m_tdata[16:0], m_tdata[32:17], m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the spread suppressor.
module testbench;
  import mscv_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [39:0]        m_tdata;
  logic               m_tlast;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = REG_FRAME_COUNT;
  logic [REG_W-1:0]   cfg_data = '0;
  int unsigned        fail_count, outstanding;
  int unsigned        cycles = 0, sent = 0, stall_left = 0, hold_left = 0;
  bit                 tx_gaps = 1, rx_gaps = 1;

  music_suppress_window_cv_unit u_dut (.*);
  mscv_checker u_chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Long output hold-off, counted down in its own process.
  always @(posedge clk) if (hold_left > 0) hold_left <= hold_left - 1;

  always @(posedge clk) begin
    int unsigned n;
    n = stall_left;
    if (m_tvalid && m_tready) n = rx_gaps ? $urandom_range(0, 8) : 0;
    else if (n > 0) n--;
    stall_left <= n;
    m_tready <= (rst || hold_left > 0 || n > 0) ? 1'b0 : 1'b1;
  end

  task automatic write_regs(logic [15:0] fc, logic [15:0] lim, logic [15:0] mf);
    logic [REG_W-1:0] vals[3];
    logic [IDX_W-1:0] idx[3];
    vals = '{fc, lim, mf};
    idx = '{REG_FRAME_COUNT, REG_SPREAD_LIMIT, REG_MIN_FRAMES};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
  endtask

  task automatic send_frame(logic [15:0] lv, logic [16:0] pv);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, pv, lv};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return 17'd65536;
      1: return 17'd0;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_sequence(int unsigned frames);
    int unsigned style, base, spread;
    int v;
    style = $urandom_range(0, 9);
    base = $urandom_range(1, 65535);
    spread = $urandom_range(0, 3) == 0 ? base : base >> $urandom_range(3, 10);
    for (int unsigned k = 0; k < frames; k++) begin
      if (style < 6) begin
        v = int'(base) + $urandom_range(0, 2 * spread) - int'(spread);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end else if (style < 8) begin
        v = $urandom_range(0, 65535);
      end else begin
        v = $urandom_range(0, 2);
      end
      send_frame(v[15:0], pick_prob());
    end
  endtask

  initial begin
    int unsigned fc, mf;
    logic [15:0] lim;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: frame count zero acts as one, so a single frame is final.
    write_regs(16'd0, SPREAD_LIMIT_RESET, 16'd0);
    send_frame(16'd0, 17'd65536);
    drain();
    write_regs(16'd3, 16'd65535, 16'd0);
    send_frame(16'd65535, 17'd0);
    send_frame(16'd0, 17'd65536);
    send_frame(16'd1, 17'd131071);
    drain();
    // Zero limit never attenuates.
    write_regs(16'd5, 16'd0, 16'd0);
    for (int k = 0; k < 5; k++) send_frame(16'(40000 + k), 17'd50000);
    drain();
    // Short sequence passes unchanged.
    write_regs(16'd4, 16'd1, 16'd200);
    for (int k = 0; k < 4; k++) send_frame(16'd1000, 17'd65536);
    drain();
    // Silent window keeps the probability.
    write_regs(16'd6, 16'd65535, 16'd0);
    for (int k = 0; k < 6; k++) send_frame(k[0] ? 16'd1 : 16'd0, 17'd65536);
    drain();

    // Count lowered in the middle of a long sequence; the next frame closes it.
    write_regs(16'd65535, 16'd65535, 16'd65535);
    run_sequence(60);
    drain();
    write_regs(16'd1, 16'd30000, 16'd0);
    send_frame(16'd20000, 17'd40000);
    drain();

    // Output held off for a long stretch while frames keep arriving.
    write_regs(16'd150, 16'd65535, 16'd0);
    hold_left <= 3000;
    tx_gaps = 0;
    run_sequence(150);
    drain();

    while (sent < 410) begin
      case ($urandom_range(0, 9))
        0, 1: fc = $urandom_range(1, 50);
        2: fc = $urandom_range(101, 130);
        default: fc = $urandom_range(60, 180);
      endcase
      case ($urandom_range(0, 5))
        0: lim = 16'd1;
        1: lim = 16'd65535;
        2: lim = 16'd0;
        default: lim = 16'($urandom_range(1000, 40000));
      endcase
      case ($urandom_range(0, 5))
        0: mf = fc;
        1: mf = fc + 1;
        2: mf = 65535;
        3: mf = $urandom_range(0, 65535);
        default: mf = 0;
      endcase
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      write_regs(fc[15:0], lim, mf[15:0]);
      run_sequence(fc);
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mscv_pkg.sv
design/music_suppress_window_cv_unit.sv
tb/mscv_checker.sv
tb/testbench.sv
